/* rtl/core/stb_pkg.sv */
// shared types and constants for the software timer bank
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

    // default sizing of the bank
    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_WIDTH_DEF = 32;

    // fixed port field widths
    localparam int OWNER_W  = 16;
    localparam int IVL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int ID_W     = 5;

    typedef enum logic {
        OP_CREATE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_CREATED = 3'd0,
        ST_FULL    = 3'd1,
        ST_INVALID = 3'd2,
        ST_FIRED   = 3'd3,
        ST_DONE    = 3'd4
    } status_t;

    // write strobes from the sequencer to the timer store
    typedef struct packed {
        logic rem_we;
        logic cfg_we;
    } mem_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/stb_mem.sv */
// timer store: remaining time and per-slot configuration memories
`timescale 1ns / 1ps
`default_nettype none

module stb_mem
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF,
    localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  wire logic                  aclk,
    input  wire mem_ctl_t              ctl,
    input  wire logic [SLOT_W-1:0]     rem_waddr,
    input  wire logic [TIME_WIDTH-1:0] rem_wdata,
    input  wire logic [SLOT_W-1:0]     cfg_waddr,
    input  wire logic [TIME_WIDTH-1:0] period_wdata,
    input  wire logic [OWNER_W-1:0]    owner_wdata,
    input  wire logic                  periodic_wdata,
    input  wire logic [SLOT_W-1:0]     rd_addr,
    output logic      [TIME_WIDTH-1:0] rd_rem,
    output logic      [TIME_WIDTH-1:0] rd_period,
    output logic      [OWNER_W-1:0]    rd_owner,
    output logic                       rd_periodic
);

    logic [TIME_WIDTH-1:0] rem_mem    [NUM_TIMERS];
    logic [TIME_WIDTH-1:0] period_mem [NUM_TIMERS];
    logic [OWNER_W-1:0]    owner_mem  [NUM_TIMERS];
    logic                  per_mem    [NUM_TIMERS];

    always_ff @(posedge aclk) begin
        if (ctl.rem_we) begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        rd_rem <= rem_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.cfg_we) begin
            period_mem[cfg_waddr] <= period_wdata;
            owner_mem[cfg_waddr]  <= owner_wdata;
            per_mem[cfg_waddr]    <= periodic_wdata;
        end
        rd_period   <= period_mem[rd_addr];
        rd_owner    <= owner_mem[rd_addr];
        rd_periodic <= per_mem[rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/core/stb_alu.sv */
// shared compare and subtract unit for the per-slot countdown
`timescale 1ns / 1ps
`default_nettype none

module stb_alu
    import stb_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic [TIME_WIDTH-1:0] remaining,
    input  wire logic [TIME_WIDTH-1:0] elapsed,
    output logic                       fire,
    output logic      [TIME_WIDTH-1:0] diff
);

    logic [TIME_WIDTH:0] sub;

    // borrow or exact zero means the timer expires on this request
    assign sub  = {1'b0, remaining} - {1'b0, elapsed};
    assign fire = sub[TIME_WIDTH] || (sub[TIME_WIDTH-1:0] == '0);
    assign diff = sub[TIME_WIDTH-1:0];

endmodule

`default_nettype wire

/* rtl/core/software_timer_bank_top.sv */
// top level of the software timer bank: request sequencer and result register
//
//   channel  dir  handshake          payload
//   s_       in   s_valid / s_ready  op, owner, interval, repeat_flag, elapsed
//   m_       out  m_valid / m_ready  status, handle, owner_out, last
//
// a create request is captured, then does the slot write and gives its result
// a tick request is captured, then each filled slot in turn goes through the shared
// compare/subtract unit, then the done result is given
// a slot that fires waits while the result register is still held by m_ready low
// s_ready is high only while no request is in work; a result may still wait
// reset clears the sequencer, the active bits and the fill count; the timer
// memories are not cleared, only filled slots are ever visited
`timescale 1ns / 1ps
`default_nettype none

module software_timer_bank_top
    import stb_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_op,
    input  wire logic [OWNER_W-1:0]  s_owner,
    input  wire logic [IVL_W-1:0]    s_interval,
    input  wire logic                s_repeat_flag,
    input  wire logic [IVL_W-1:0]    s_elapsed,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [STATUS_W-1:0]      m_status,
    output logic [ID_W-1:0]          m_handle,
    output logic [OWNER_W-1:0]       m_owner_out,
    output logic                     m_last
);

    localparam int SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W  = $clog2(NUM_TIMERS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CREATE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                state_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    logic [CNT_W-1:0]      used_reg;
    logic [NUM_TIMERS-1:0] active_reg;

    // captured request
    logic [TIME_WIDTH-1:0] ivl_reg;
    logic [TIME_WIDTH-1:0] el_reg;
    logic [OWNER_W-1:0]    owner_reg;
    logic                  rep_reg;

    // result register
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [ID_W-1:0]       m_handle_reg;
    logic [OWNER_W-1:0]    m_owner_out_reg;
    logic                  m_last_reg;

    // request fields brought to the time width (zero extend or truncate)
    logic [TIME_WIDTH+IVL_W-1:0] ivl_wide;
    logic [TIME_WIDTH+IVL_W-1:0] el_wide;

    // store read data for slot_reg
    logic [TIME_WIDTH-1:0] rd_rem;
    logic [TIME_WIDTH-1:0] rd_period;
    logic [OWNER_W-1:0]    rd_owner;
    logic                  rd_periodic;

    logic                  alu_fire;
    logic [TIME_WIDTH-1:0] alu_diff;

    mem_ctl_t              mem_ctl;
    logic [SLOT_W-1:0]     rem_waddr;
    logic [TIME_WIDTH-1:0] rem_wdata;

    logic                  out_free;
    logic                  slot_act;
    logic                  slot_fire;
    logic                  step_ok;
    logic                  slot_last;
    logic                  create_ok;
    logic [CNT_W-1:0]      slot_id;
    logic [CNT_W-1:0]      used_id;
    logic [CNT_W+ID_W-1:0] slot_id_wide;
    logic [CNT_W+ID_W-1:0] used_id_wide;

    assign ivl_wide = {{TIME_WIDTH{1'b0}}, s_interval};
    assign el_wide  = {{TIME_WIDTH{1'b0}}, s_elapsed};

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_handle    = m_handle_reg;
    assign m_owner_out = m_owner_out_reg;
    assign m_last      = m_last_reg;

    // result register can take a new result this cycle
    assign out_free = !m_valid_reg || m_ready;

    // slot under test in the scan
    assign slot_act  = active_reg[slot_reg];
    assign slot_fire = slot_act && alu_fire;
    assign step_ok   = !slot_fire || out_free;
    assign slot_id   = CNT_W'(slot_reg) + CNT_W'(1);
    assign slot_last = (slot_id == used_reg);

    // timer ids are slot + 1, cut to the id field
    assign used_id      = used_reg + CNT_W'(1);
    assign slot_id_wide = {{ID_W{1'b0}}, slot_id};
    assign used_id_wide = {{ID_W{1'b0}}, used_id};

    assign create_ok = (ivl_reg != '0) && (used_reg != CNT_W'(NUM_TIMERS));

    // next slot also drives the registered store read
    always_comb begin
        slot_next = slot_reg;
        if (state_reg == S_IDLE) begin
            slot_next = '0;
        end else if ((state_reg == S_SCAN) && step_ok && !slot_last) begin
            slot_next = slot_reg + SLOT_W'(1);
        end
    end

    // store writes: new timer on create, countdown or reload on tick
    always_comb begin
        mem_ctl.cfg_we = (state_reg == S_CREATE) && out_free && create_ok;
        mem_ctl.rem_we = mem_ctl.cfg_we ||
                         ((state_reg == S_SCAN) && slot_act && step_ok &&
                          (!alu_fire || rd_periodic));
        if (state_reg == S_CREATE) begin
            rem_waddr = used_reg[SLOT_W-1:0];
            rem_wdata = ivl_reg;
        end else begin
            rem_waddr = slot_reg;
            rem_wdata = alu_fire ? rd_period : alu_diff;
        end
    end

    stb_mem #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_mem (
        .aclk           (aclk),
        .ctl            (mem_ctl),
        .rem_waddr      (rem_waddr),
        .rem_wdata      (rem_wdata),
        .cfg_waddr      (used_reg[SLOT_W-1:0]),
        .period_wdata   (ivl_reg),
        .owner_wdata    (owner_reg),
        .periodic_wdata (rep_reg),
        .rd_addr        (slot_next),
        .rd_rem         (rd_rem),
        .rd_period      (rd_period),
        .rd_owner       (rd_owner),
        .rd_periodic    (rd_periodic)
    );

    stb_alu #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_alu (
        .remaining (rd_rem),
        .elapsed   (el_reg),
        .fire      (alu_fire),
        .diff      (alu_diff)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            slot_reg    <= '0;
            used_reg    <= '0;
            active_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            slot_reg <= slot_next;
            // result taken downstream
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        ivl_reg   <= ivl_wide[TIME_WIDTH-1:0];
                        el_reg    <= el_wide[TIME_WIDTH-1:0];
                        owner_reg <= s_owner;
                        rep_reg   <= s_repeat_flag;
                        if (s_op == OP_TICK) begin
                            state_reg <= (used_reg == '0) ? S_DONE : S_SCAN;
                        end else begin
                            state_reg <= S_CREATE;
                        end
                    end
                end
                S_CREATE: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_owner_out_reg <= '0;
                        m_last_reg      <= 1'b1;
                        m_handle_reg    <= '0;
                        // zero interval is checked ahead of the full table
                        if (ivl_reg == '0) begin
                            m_status_reg <= ST_INVALID;
                        end else if (!create_ok) begin
                            m_status_reg <= ST_FULL;
                        end else begin
                            m_status_reg   <= ST_CREATED;
                            m_handle_reg   <= used_id_wide[ID_W-1:0];
                            active_reg[used_reg[SLOT_W-1:0]] <= 1'b1;
                            used_reg       <= used_id;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (slot_fire && out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_status_reg    <= ST_FIRED;
                        m_handle_reg    <= slot_id_wide[ID_W-1:0];
                        m_owner_out_reg <= rd_owner;
                        m_last_reg      <= 1'b0;
                        if (!rd_periodic) begin
                            active_reg[slot_reg] <= 1'b0;
                        end
                    end
                    if (step_ok && slot_last) begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg     <= 1'b1;
                        m_status_reg    <= ST_DONE;
                        m_handle_reg    <= '0;
                        m_owner_out_reg <= '0;
                        m_last_reg      <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/stb_checker.sv */
// port-level checker for the software timer bank, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module stb_checker
    import stb_pkg::*;
(
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire logic [STATUS_W-1:0] m_status,
    input wire logic [ID_W-1:0]     m_handle,
    input wire logic [OWNER_W-1:0]  m_owner_out,
    input wire logic                m_last
);

    // no result pending right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_handle)
            && $stable(m_owner_out) && $stable(m_last))
        else $error("held result changed");

    // the bank is not ready in the cycle after it takes a request
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken back to back");

    // only fired events come before the final result of a request
    a_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_status == ST_FIRED && m_handle != '0)
        else $error("non-final result is not a fired event");

    // a created timer always gets a nonzero id and ends its request
    a_created: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_CREATED |-> m_last && m_handle != '0
            && m_owner_out == '0)
        else $error("bad create result");

endmodule

bind software_timer_bank_top stb_checker u_stb_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_handle    (m_handle),
    .m_owner_out (m_owner_out),
    .m_last      (m_last)
);

`default_nettype wire
